@@ rtl/core/fpa_pkg.sv @@
// shared types, constants and the helper function of the fixed-point unit
package fpa_pkg;
	localparam int WordWidth = 32;
	localparam int CfgWidth = 6;
	localparam int QueueDepth = 4;
	localparam int DivBitsPerStage = 4;
	localparam int DivStages = 2 * WordWidth / DivBitsPerStage;

	localparam logic [1:0] CFG_INT_BITS = 2'd0;
	localparam logic [1:0] CFG_FRAC_BITS = 2'd1;
	localparam logic [1:0] CFG_ROUND_MODE = 2'd2;

	localparam logic [1:0] RND_ZERO = 2'd0;
	localparam logic [1:0] RND_EVEN = 2'd1;
	localparam logic [1:0] RND_POS = 2'd2;
	localparam logic [1:0] RND_NEG = 2'd3;

	typedef enum logic [2:0] {
		F_ADD = 3'd0,
		F_SUB = 3'd1,
		F_MUL = 3'd2,
		F_DIV = 3'd3,
		F_NEG = 3'd4
	} func_t;

	typedef struct packed {
		logic [2:0] op;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] ma;
		logic [31:0] mb;
		logic nr;
		logic [31:0] mask;
		logic [4:0] frac;
		logic [1:0] mode;
	} item_t;

	typedef struct packed {
		item_t it;
		logic dz;
		logic [31:0] mres;
		logic [32:0] rem;
		logic [63:0] dvd;
		logic [31:0] quo;
	} stage_t;

	typedef struct packed {
		logic nonempty;
		logic pop;
	} qctl_t;

	function automatic logic [128:0] div_step(logic [32:0] rem, logic [63:0] dvd,
			logic [31:0] quo, logic [31:0] d);
		logic [32:0] r;
		logic [63:0] x;
		logic [31:0] q;
		r = rem;
		x = dvd;
		q = quo;
		for (int i = 0; i < DivBitsPerStage; i++) begin
			r = {r[31:0], x[63]};
			x = {x[62:0], 1'b0};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q = {q[30:0], 1'b1};
			end else begin
				q = {q[30:0], 1'b0};
			end
		end
		return {r[32:0], x, q};
	endfunction
endpackage

@@ rtl/core/fixed_point_alu_with_rounding_core.sv @@
// top level of the fixed-point unit with rounding
//  channel | handshake                  | payload
//  config  | cfg_wr_en                  | cfg_index, cfg_data
//  input   | in_valid / in_stall        | func, operand_a, operand_b
//  output  | out_valid / out_stall      | result, div_by_zero
// one item per cycle sustained while out_stall is low; from input accept to output valid an item passes:
// queue, multiplier stage, rounding stage, 16 divide stages of 4 bits, output register
// in_stall rises only when the 4-entry queue is full
// out_stall freezes the whole back end; no clearing pass after reset
module fixed_point_alu_with_rounding_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [1:0] cfg_index,
	input logic [fpa_pkg::CfgWidth-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] func,
	input logic [31:0] operand_a,
	input logic [31:0] operand_b,
	output logic out_valid,
	input logic out_stall,
	output logic [31:0] result,
	output logic div_by_zero
);
	import fpa_pkg::*;

	item_t f_item, q_item;
	qctl_t qctl;
	logic full;

	assign in_stall = full;

	fpa_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.func(func), .operand_a(operand_a), .operand_b(operand_b),
		.item(f_item)
	);

	fpa_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(in_valid && !full), .wr_item(f_item), .full(full),
		.pop(qctl.pop), .nonempty(qctl.nonempty), .rd_item(q_item)
	);

	fpa_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_nonempty(qctl.nonempty), .q_item(q_item), .q_pop(qctl.pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.result(result), .div_by_zero(div_by_zero)
	);
endmodule

@@ rtl/core/fpa_front.sv @@
// front end: configuration registers, operand masking and sign handling
module fpa_front (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [1:0] cfg_index,
	input logic [fpa_pkg::CfgWidth-1:0] cfg_data,
	input logic [2:0] func,
	input logic [31:0] operand_a,
	input logic [31:0] operand_b,
	output fpa_pkg::item_t item
);
	import fpa_pkg::*;

	logic [5:0] int_bits_q;
	logic [4:0] frac_bits_q;
	logic [1:0] mode_q;
	logic [5:0] ib;
	logic [6:0] wsum;
	logic [5:0] w;
	logic [4:0] wm1;
	logic [32:0] mask_w;
	logic [31:0] mask;
	logic [31:0] a, b;
	logic na, nb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_bits_q <= 6'd16;
			frac_bits_q <= 5'd16;
			mode_q <= RND_ZERO;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_INT_BITS: int_bits_q <= cfg_data;
				CFG_FRAC_BITS: frac_bits_q <= cfg_data[4:0];
				CFG_ROUND_MODE: mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ib = (int_bits_q == 6'd0) ? 6'd1 : int_bits_q;
		wsum = {1'b0, ib} + {2'b0, frac_bits_q};
		w = (wsum > 7'd32) ? 6'd32 : wsum[5:0];
		wm1 = 5'(w - 6'd1);
		mask_w = (33'd1 << w) - 33'd1;
		mask = mask_w[31:0];
		a = operand_a & mask;
		b = operand_b & mask;
		na = a[wm1];
		nb = b[wm1];
		item.op = func;
		item.a = a;
		item.b = b;
		item.ma = na ? ((32'd0 - a) & mask) : a;
		item.mb = nb ? ((32'd0 - b) & mask) : b;
		item.nr = na ^ nb;
		item.mask = mask;
		item.frac = (frac_bits_q > wm1) ? wm1 : frac_bits_q;
		item.mode = mode_q;
	end
endmodule

@@ rtl/core/fpa_queue.sv @@
// short item queue between front end and back end
module fpa_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input fpa_pkg::item_t wr_item,
	output logic full,
	input logic pop,
	output logic nonempty,
	output fpa_pkg::item_t rd_item
);
	import fpa_pkg::*;

	localparam int PtrW = $clog2(QueueDepth);

	item_t mem_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PtrW:0] count_q;

	assign full = (count_q == (PtrW+1)'(QueueDepth));
	assign nonempty = (count_q != '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty) else $error("queue pop while empty");
`endif
endmodule

@@ rtl/core/fpa_back.sv @@
// back end: multiply, rounding, pipelined divide, result selection and result register
module fpa_back (
	input logic clk,
	input logic arst_n,
	input logic q_nonempty,
	input fpa_pkg::item_t q_item,
	output logic q_pop,
	output logic out_valid,
	input logic out_stall,
	output logic [31:0] result,
	output logic div_by_zero
);
	import fpa_pkg::*;

	localparam int Last = DivStages + 1;

	stage_t pipe_q [Last+1];
	logic [Last:0] vld_q;
	logic [63:0] prod_s1;
	logic en;
	logic out_valid_q;
	logic [31:0] result_q;
	logic dz_q;
	logic [63:0] fmask, rem, half, kept;
	logic inc;
	logic [31:0] t, r;
	stage_t st;

	assign en = !out_valid_q || !out_stall;
	assign q_pop = en && q_nonempty;
	assign out_valid = out_valid_q;
	assign result = result_q;
	assign div_by_zero = dz_q;

	always_comb begin
		fmask = (64'd1 << pipe_q[0].it.frac) - 64'd1;
		rem = prod_s1 & fmask;
		kept = prod_s1 >> pipe_q[0].it.frac;
		half = (64'd1 << pipe_q[0].it.frac) >> 1;
		inc = 1'b0;
		if (rem != 64'd0) begin
			unique case (pipe_q[0].it.mode)
				RND_EVEN: inc = (rem > half) || (rem == half && kept[0]);
				RND_POS: inc = !pipe_q[0].it.nr;
				RND_NEG: inc = pipe_q[0].it.nr;
				default: inc = 1'b0;
			endcase
		end
		t = kept[31:0] + {31'd0, inc};
	end

	always_comb begin
		st = pipe_q[Last];
		unique case (st.it.op)
			F_ADD: r = st.it.a + st.it.b;
			F_SUB: r = st.it.a - st.it.b;
			F_MUL: r = st.it.nr ? 32'd0 - st.mres : st.mres;
			F_DIV: r = st.dz ? 32'd0 : (st.it.nr ? 32'd0 - st.quo : st.quo);
			F_NEG: r = 32'd0 - st.it.a;
			default: r = 32'd0;
		endcase
		r = r & st.it.mask;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_q[0].it <= q_item;
			prod_s1 <= 64'(q_item.ma) * 64'(q_item.mb);
			pipe_q[1].it <= pipe_q[0].it;
			pipe_q[1].dz <= (pipe_q[0].it.mb == 32'd0);
			pipe_q[1].mres <= t;
			pipe_q[1].rem <= '0;
			pipe_q[1].dvd <= {32'd0, pipe_q[0].it.ma} << pipe_q[0].it.frac;
			pipe_q[1].quo <= '0;
			for (int s = 2; s <= Last; s++) begin
				pipe_q[s].it <= pipe_q[s-1].it;
				pipe_q[s].dz <= pipe_q[s-1].dz;
				pipe_q[s].mres <= pipe_q[s-1].mres;
				{pipe_q[s].rem, pipe_q[s].dvd, pipe_q[s].quo} <= div_step(
					pipe_q[s-1].rem, pipe_q[s-1].dvd, pipe_q[s-1].quo,
					pipe_q[s-1].it.mb);
			end
			result_q <= r;
			dz_q <= (st.it.op == F_DIV) && st.dz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[Last-1:0], q_nonempty};
			out_valid_q <= vld_q[Last];
		end
	end

`ifndef SYNTH
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(result_q))
		else $error("result dropped under stall");
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && dz_q |-> result_q == 32'd0)
		else $error("divide by zero with nonzero result");
`endif
endmodule
